// File: rtl/lsac_pkg.sv
package lsac_pkg;

	localparam int SETS        = 1024;
	localparam int WAYS        = 4;
	localparam int BLOCK_BYTES = 8;
	localparam int ADDR_W      = 32;
	localparam int OFF_W       = $clog2(BLOCK_BYTES);
	localparam int SET_W       = $clog2(SETS);
	localparam int TAG_W       = ADDR_W - OFF_W - SET_W;
	localparam int WAY_W       = 2;
	localparam int RANK_W      = $clog2(WAYS);
	localparam int FILL_W      = $clog2(WAYS + 1);
	localparam int VTAG_W      = 19;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FETCH = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic              dirty;
		logic [RANK_W-1:0] rank;
	} line_t;

	typedef struct packed {
		logic [FILL_W-1:0]    fill;
		line_t [WAYS-1:0]     lines;
	} row_t;

	typedef struct packed {
		logic              ignored;
		logic              hit;
		logic [WAY_W-1:0]  way_used;
		logic              write_back;
		logic [VTAG_W-1:0] victim_tag;
	} res_t;

endpackage

// File: rtl/lsac_mem.sv
module lsac_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [lsac_pkg::SET_W-1:0] waddr,
	input  lsac_pkg::row_t            wdata,
	input  logic [lsac_pkg::SET_W-1:0] raddr,
	output lsac_pkg::row_t            rdata
);

	lsac_pkg::row_t mem [lsac_pkg::SETS];
	lsac_pkg::row_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/lsac_upd.sv
module lsac_upd (
	input  lsac_pkg::row_t                row,
	input  logic [1:0]                    command,
	input  logic [lsac_pkg::ADDR_W-1:0]   byte_address,
	output lsac_pkg::row_t                row_new,
	output lsac_pkg::res_t                res,
	output logic                          wr
);

	localparam int WAYS   = lsac_pkg::WAYS;
	localparam int WAY_W  = lsac_pkg::WAY_W;
	localparam int FILL_W = lsac_pkg::FILL_W;
	localparam int TAG_W  = lsac_pkg::TAG_W;
	localparam int VTAG_W = lsac_pkg::VTAG_W;
	localparam int ADDR_W = lsac_pkg::ADDR_W;

	logic              ign;
	logic              is_wr;
	logic [TAG_W-1:0]  tag;
	logic [FILL_W-1:0] fill;
	logic [FILL_W-1:0] fill_new;
	logic [FILL_W-1:0] old;
	logic              hit;
	logic              wb;
	logic [WAY_W-1:0]  w;

	always_comb begin
		ign   = (command == lsac_pkg::CMD_NONE) ||
		        ((command == lsac_pkg::CMD_FETCH) && (byte_address == '1));
		is_wr = (command == lsac_pkg::CMD_WRITE);
		tag   = byte_address[ADDR_W-1 -: TAG_W];
		fill  = (row.fill > FILL_W'(WAYS)) ? FILL_W'(WAYS) : row.fill;

		hit = 1'b0;
		w   = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (!hit && (FILL_W'(i) < fill) && (row.lines[i].tag == tag)) begin
				hit = 1'b1;
				w   = WAY_W'(i);
			end
		end

		row_new  = row;
		fill_new = fill;
		old      = '0;
		wb       = 1'b0;

		if (hit) begin
			old = FILL_W'(row.lines[w].rank);
			if (is_wr) begin
				row_new.lines[w].dirty = 1'b1;
			end
		end else begin
			if (fill < FILL_W'(WAYS)) begin
				w        = WAY_W'(fill);
				old      = fill;
				fill_new = fill + 1'b1;
			end else begin
				w = '0;
				for (int i = 1; i < WAYS; i++) begin
					if (row.lines[i].rank > row.lines[w].rank) begin
						w = WAY_W'(i);
					end
				end
				old = FILL_W'(row.lines[w].rank);
				wb  = row.lines[w].dirty;
			end
			row_new.lines[w].tag   = tag;
			row_new.lines[w].dirty = is_wr;
		end

		// true LRU: ways more recent than the touched one age by one
		for (int i = 0; i < WAYS; i++) begin
			if ((FILL_W'(i) < fill_new) && (WAY_W'(i) != w) &&
			    (FILL_W'(row.lines[i].rank) < old)) begin
				row_new.lines[i].rank = row.lines[i].rank + 1'b1;
			end
		end
		row_new.lines[w].rank = '0;
		row_new.fill          = fill_new;

		res            = '0;
		res.hit        = hit;
		res.way_used   = w;
		res.write_back = wb;
		res.victim_tag = wb ? VTAG_W'(row.lines[w].tag) : '0;
		if (ign) begin
			res         = '0;
			res.ignored = 1'b1;
		end
		wr = !ign;
	end

endmodule

// File: rtl/lru_set_assoc_writeback_cache.sv
// done is registered from the look-up state that follows the accept of start.
// A new word is taken only after the look-up of the last one; the set row is read from the tag RAM,
// then modified and written back through the same RAM before the next accept.
// Reset: arst_n clears control; a clearing pass then zeroes every set row,
// with busy high. done lasts one cycle and the receiver cannot stall it.
module lru_set_assoc_writeback_cache (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        command,
	input  logic [lsac_pkg::ADDR_W-1:0]       byte_address,
	output logic                              done,
	output logic                              ignored,
	output logic                              hit,
	output logic [lsac_pkg::WAY_W-1:0]        way_used,
	output logic                              write_back,
	output logic [lsac_pkg::VTAG_W-1:0]       victim_tag
);

	localparam int SET_W = lsac_pkg::SET_W;
	localparam int OFF_W = lsac_pkg::OFF_W;

	lsac_pkg::state_t state_q, state_d;
	logic [SET_W-1:0] clr_cnt_q;
	logic [1:0]       cmd_q;
	logic [lsac_pkg::ADDR_W-1:0] addr_q;
	logic             done_q;
	lsac_pkg::res_t   res_q;

	logic             we;
	logic [SET_W-1:0] waddr;
	logic [SET_W-1:0] raddr;
	lsac_pkg::row_t   wdata;
	lsac_pkg::row_t   rdata;
	lsac_pkg::row_t   row_new;
	lsac_pkg::res_t   res;
	logic             upd_wr;
	logic             accept;

	lsac_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	lsac_upd u_upd (
		.row          (rdata),
		.command      (cmd_q),
		.byte_address (addr_q),
		.row_new      (row_new),
		.res          (res),
		.wr           (upd_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lsac_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == lsac_pkg::ST_LOOK);
			if (state_q == lsac_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			addr_q <= byte_address;
		end
		if (state_q == lsac_pkg::ST_LOOK) begin
			res_q <= res;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		accept  = 1'b0;
		we      = 1'b0;
		waddr   = addr_q[OFF_W +: SET_W];
		wdata   = row_new;
		raddr   = byte_address[OFF_W +: SET_W];
		case (state_q)
			lsac_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_cnt_q;
				wdata = '0;
				if (clr_cnt_q == SET_W'(lsac_pkg::SETS - 1)) begin
					state_d = lsac_pkg::ST_IDLE;
				end
			end
			lsac_pkg::ST_IDLE: begin
				busy   = 1'b0;
				accept = start;
				if (start) begin
					state_d = lsac_pkg::ST_LOOK;
				end
			end
			lsac_pkg::ST_LOOK: begin
				we      = upd_wr;
				state_d = lsac_pkg::ST_IDLE;
			end
			default: begin
				state_d = lsac_pkg::ST_IDLE;
			end
		endcase
	end

	assign done       = done_q;
	assign ignored    = res_q.ignored;
	assign hit        = res_q.hit;
	assign way_used   = res_q.way_used;
	assign write_back = res_q.write_back;
	assign victim_tag = res_q.victim_tag;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("done missing two cycles after accept");

	a_no_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted while row update pending");

	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && write_back))
		else $error("write-back reported on a hit");

	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ignored) |-> (!hit && !write_back && way_used == '0 && victim_tag == '0))
		else $error("ignored word carries nonzero fields");

	a_vtag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !write_back) |-> (victim_tag == '0))
		else $error("victim tag without write-back");
`endif

endmodule
